// ===== rtl/alert_indicator_controller_defines.svh =====
// Assertion helpers for the RTL file that checks its own logic.
`ifndef ALERT_INDICATOR_CONTROLLER_DEFINES_SVH
`define ALERT_INDICATOR_CONTROLLER_DEFINES_SVH

// The consequence must hold in the same cycle as the condition.
`define AIC_ASSERT_NOW(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("aic check failed in the same cycle");

// The consequence must hold in the cycle after the condition.
`define AIC_ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("aic check failed in the following cycle");

`endif

// ===== rtl/aic_pkg.sv =====
`default_nettype none

package aic_pkg;

   localparam int TIME_W      = 32;
   localparam int LEVEL_W     = 3;
   localparam int CODE_W      = 3;
   localparam int OP_W        = 2;
   localparam int DURATION_W  = 24;
   localparam int INTERVAL_W  = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_W-1:0] OP_SET   = 2'd1;
   localparam logic [OP_W-1:0] OP_EVENT = 2'd2;

   localparam logic [LEVEL_W-1:0] LEVEL_OFF     = 3'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_CRIT    = 3'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_WARN    = 3'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_INFO    = 3'd3;
   localparam logic [LEVEL_W-1:0] LEVEL_SUCCESS = 3'd4;

   localparam logic [CODE_W-1:0] BTN_UNKNOWN = 3'd0;
   localparam logic [CODE_W-1:0] BTN_ACK     = 3'd1;
   localparam logic [CODE_W-1:0] BTN_CLEAR   = 3'd2;
   localparam logic [CODE_W-1:0] BTN_SERVICE = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] REG_BLOCK_ENABLE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BUZZER_ENABLE  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ALERT_DURATION = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BLINK_INTERVAL = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE_TIME  = 3'd4;

   localparam logic [DURATION_W-1:0] RST_ALERT_DURATION = 24'd30000;
   localparam logic [INTERVAL_W-1:0] RST_BLINK_INTERVAL = 16'd500;
   localparam logic [INTERVAL_W-1:0] RST_DEBOUNCE_TIME  = 16'd50;

   typedef struct packed {
      logic                  block_enable;
      logic                  buzzer_enable;
      logic [DURATION_W-1:0] alert_duration;
      logic [INTERVAL_W-1:0] blink_interval;
      logic [INTERVAL_W-1:0] debounce_time;
   } cfg_type;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [LEVEL_W-1:0] new_level;
      logic [CODE_W-1:0]  button_code;
   } item_type;

   typedef struct packed {
      logic [TIME_W-1:0]  time_ms;
      logic [LEVEL_W-1:0] level;
      logic               active;
      logic               acked;
      logic [TIME_W-1:0]  start_time;
      logic               blink_phase;
      logic [TIME_W-1:0]  last_toggle_time;
      logic [TIME_W-1:0]  last_button_time;
   } state_type;

   typedef struct packed {
      logic               led_crit;
      logic               led_warn;
      logic               led_inform;
      logic               led_ok;
      logic               buzzer_on;
      logic               alert_is_active;
      logic               alert_is_acked;
      logic [LEVEL_W-1:0] level_now;
      logic               set_accepted;
      logic               event_accepted;
      logic [CODE_W-1:0]  event_out;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/aic_step.sv =====
`default_nettype none

// Next-state and result logic for one word: if enabled, applies the op,
// then the timeout and blink rules, then decodes the indicators.
module aic_step (
   input  wire aic_pkg::cfg_type    cfg,
   input  wire aic_pkg::state_type  cur,
   input  wire aic_pkg::item_type   item,
   output aic_pkg::state_type       nxt,
   output aic_pkg::result_type      res
);

   logic [aic_pkg::CODE_W-1:0] code;
   logic [aic_pkg::TIME_W-1:0] since_button;
   logic [aic_pkg::TIME_W-1:0] since_start;
   logic [aic_pkg::TIME_W-1:0] since_toggle;
   logic                       blinking;
   logic                       shown;

   always_comb begin
      nxt          = cur;
      res          = '0;
      code         = (item.button_code > aic_pkg::BTN_SERVICE) ?
                     aic_pkg::BTN_UNKNOWN : item.button_code;
      since_button = cur.time_ms - cur.last_button_time;
      since_start  = '0;
      since_toggle = '0;
      blinking     = 1'b0;
      shown        = 1'b0;

      if (cfg.block_enable) begin
         unique case (item.op)
            aic_pkg::OP_TICK: begin
               nxt.time_ms = cur.time_ms + 1'b1;
            end
            aic_pkg::OP_SET: begin
               if (item.new_level <= aic_pkg::LEVEL_SUCCESS) begin
                  nxt.level      = item.new_level;
                  nxt.start_time = cur.time_ms;
                  nxt.active     = (item.new_level != aic_pkg::LEVEL_OFF);
                  nxt.acked      = 1'b0;
                  res.set_accepted = 1'b1;
               end
            end
            aic_pkg::OP_EVENT: begin
               if (since_button >= {16'd0, cfg.debounce_time}) begin
                  nxt.last_button_time = cur.time_ms;
                  if (code == aic_pkg::BTN_ACK) begin
                     nxt.acked = 1'b1;
                  end else if (code == aic_pkg::BTN_CLEAR) begin
                     nxt.level  = aic_pkg::LEVEL_OFF;
                     nxt.active = 1'b0;
                     nxt.acked  = 1'b0;
                  end
                  res.event_accepted = 1'b1;
                  res.event_out      = code;
               end
            end
            default: begin
            end
         endcase

         // An unacknowledged alert that has outlived its duration goes off.
         since_start = nxt.time_ms - nxt.start_time;
         if (nxt.active && !nxt.acked && (since_start > {8'd0, cfg.alert_duration})) begin
            nxt.active = 1'b0;
            nxt.level  = aic_pkg::LEVEL_OFF;
         end

         blinking     = nxt.active && !nxt.acked;
         since_toggle = nxt.time_ms - nxt.last_toggle_time;
         if (blinking && (since_toggle >= {16'd0, cfg.blink_interval})) begin
            nxt.blink_phase      = !nxt.blink_phase;
            nxt.last_toggle_time = nxt.time_ms;
         end

         shown = blinking ? nxt.blink_phase : 1'b1;
         if (shown) begin
            unique case (nxt.level)
               aic_pkg::LEVEL_CRIT: begin
                  res.led_crit  = 1'b1;
                  res.buzzer_on = cfg.buzzer_enable;
               end
               aic_pkg::LEVEL_WARN:    res.led_warn   = 1'b1;
               aic_pkg::LEVEL_INFO:    res.led_inform = 1'b1;
               aic_pkg::LEVEL_SUCCESS: res.led_ok     = 1'b1;
               default: begin
               end
            endcase
         end
      end

      res.alert_is_active = nxt.active;
      res.alert_is_acked  = nxt.acked;
      res.level_now       = nxt.level;
   end

endmodule

`default_nettype wire

// ===== rtl/alert_indicator_controller.sv =====
`default_nettype none

// Alert indicator controller. Each request word is a millisecond tick, a
// new alert level or a button event (kind in req_tuser); each one yields
// exactly one response word with the four one-hot indicator drives, the
// buzzer drive and the alert status. The block takes one word per clock
// unless the response side stalls. An accepted word lands in an input
// register; once the result register is free or draining, the next-state
// logic (a 32-bit tick increment followed by the elapsed-time subtract and
// compare) fills the result register and the alert state, from which the
// response word is driven. A stalled response holds the result register,
// and one more request can wait in the input register.
// Configuration writes on the csr_ port are always ready and take effect
// at once; write them only while no word is in flight.
module alert_indicator_controller (
   input  wire         clock,
   input  wire         reset,
   // Request: tdata = {2'b0, button_code[2:0], new_level[2:0]}, tuser = op[1:0]
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,
   input  wire  [1:0]  req_tuser,
   // Response, from bit 0 up: led_crit, led_warn, led_inform, led_ok,
   // buzzer_on, alert_is_active, alert_is_acked, level_now[2:0],
   // set_accepted, event_accepted, event_out[2:0], one zero bit
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,
   // Register writes
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [aic_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire  [aic_pkg::CSR_DATA_W-1:0]  csr_data
);

   aic_pkg::cfg_type    cfg_ff;
   aic_pkg::state_type  state_ff;
   aic_pkg::state_type  state_in;
   aic_pkg::item_type   item_ff;
   aic_pkg::result_type res_in;
   aic_pkg::result_type res_ff;
   logic                in_valid_ff;
   logic                out_valid_ff;
   logic                advance;
   logic                tick_taken;

   // The held word moves on whenever the result register is free or draining.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign tick_taken = advance && cfg_ff.block_enable && (item_ff.op == aic_pkg::OP_TICK);

   aic_step u_step (
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .item (item_ff),
      .nxt  (state_in),
      .res  (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_enable   <= 1'b1;
         cfg_ff.buzzer_enable  <= 1'b1;
         cfg_ff.alert_duration <= aic_pkg::RST_ALERT_DURATION;
         cfg_ff.blink_interval <= aic_pkg::RST_BLINK_INTERVAL;
         cfg_ff.debounce_time  <= aic_pkg::RST_DEBOUNCE_TIME;
      end else if (csr_valid) begin
         unique case (csr_index)
            aic_pkg::REG_BLOCK_ENABLE:   cfg_ff.block_enable   <= csr_data[0];
            aic_pkg::REG_BUZZER_ENABLE:  cfg_ff.buzzer_enable  <= csr_data[0];
            aic_pkg::REG_ALERT_DURATION: cfg_ff.alert_duration <= csr_data;
            aic_pkg::REG_BLINK_INTERVAL:
               cfg_ff.blink_interval <= csr_data[aic_pkg::INTERVAL_W-1:0];
            aic_pkg::REG_DEBOUNCE_TIME:
               cfg_ff.debounce_time  <= csr_data[aic_pkg::INTERVAL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            state_ff     <= state_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.op          <= req_tuser;
         item_ff.new_level   <= req_tdata[2:0];
         item_ff.button_code <= req_tdata[5:3];
      end
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0,
                        res_ff.event_out,
                        res_ff.event_accepted,
                        res_ff.set_accepted,
                        res_ff.level_now,
                        res_ff.alert_is_acked,
                        res_ff.alert_is_active,
                        res_ff.buzzer_on,
                        res_ff.led_ok,
                        res_ff.led_inform,
                        res_ff.led_warn,
                        res_ff.led_crit};

`include "alert_indicator_controller_defines.svh"

   // A held request word is never dropped while the result side is stalled.
   `AIC_ASSERT_NEXT(a_held_word_kept, clock, reset, in_valid_ff && !advance, in_valid_ff)
   // Every word that leaves the input register shows up as a response word.
   `AIC_ASSERT_NEXT(a_advance_fills_result, clock, reset, advance, out_valid_ff)
   // The millisecond clock only moves on an enabled tick.
   `AIC_ASSERT_NEXT(a_time_only_on_tick, clock, reset, !tick_taken, $stable(state_ff.time_ms))

endmodule

`default_nettype wire

// ===== tb/sv/alert_indicator_controller_tb.sv =====
`default_nettype none

module alert_indicator_controller_tb;

   localparam logic [aic_pkg::OP_W-1:0]    OP_UNUSED = 2'd3;
   localparam logic [aic_pkg::CODE_W-1:0]  BTN_TRAIN = 3'd3;
   localparam int                          LEVEL_TOP = (1 << aic_pkg::LEVEL_W) - 1;
   localparam int                          CODE_TOP  = (1 << aic_pkg::CODE_W) - 1;
   localparam logic [aic_pkg::LEVEL_W-1:0] LEVEL_ALL = '1;
   localparam logic [aic_pkg::CODE_W-1:0]  CODE_ALL  = '1;
   localparam logic [aic_pkg::LEVEL_W-1:0] LEVEL_BAD = aic_pkg::LEVEL_SUCCESS + 3'd1;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [7:0]                      req_tdata;   // new_level[2:0], button_code[5:3], zeros
   logic [1:0]                      req_tuser;   // op[1:0]
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   // led_crit, led_warn, led_inform, led_ok, buzzer_on, alert_is_active,
   // alert_is_acked, level_now[9:7], set_accepted, event_accepted,
   // event_out[14:12], zero
   logic [15:0]                     rsp_tdata;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [aic_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [aic_pkg::CSR_DATA_W-1:0]  csr_data;

   alert_indicator_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Our own copy of the alert state and the register settings.
   aic_pkg::cfg_type            cfg;
   logic [aic_pkg::TIME_W-1:0]  now_ms;
   logic [aic_pkg::LEVEL_W-1:0] level_q;
   logic                        alarm_on;
   logic                        alert_acked;
   logic [aic_pkg::TIME_W-1:0]  alert_start;
   logic                        blink_on;
   logic [aic_pkg::TIME_W-1:0]  last_toggle;
   logic [aic_pkg::TIME_W-1:0]  last_press;

   aic_pkg::result_type expected_status[$];
   aic_pkg::result_type status_due;
   logic [15:0]         want_word;

   int  error_count   = 0;
   int  items_sent    = 0;
   int  words_checked = 0;
   int  settings_used = 0;
   bit  idle_on       = 1'b1;
   int  hold_left     = 0;
   int  stall_left    = 0;

   task automatic report_error(input string msg);
      error_count++;
      $display("ERROR at %0t: %s", $time, msg);
   endtask

   // Lays out a status the way the response word carries it.
   function automatic logic [15:0] pack_status(input aic_pkg::result_type r);
      return {1'b0, r.event_out, r.event_accepted, r.set_accepted, r.level_now,
              r.alert_is_acked, r.alert_is_active, r.buzzer_on, r.led_ok,
              r.led_inform, r.led_warn, r.led_crit};
   endfunction

   // Applies one request word to the state copy and returns the status it yields.
   function automatic aic_pkg::result_type advance_alert(input aic_pkg::item_type it);
      aic_pkg::result_type        r;
      logic [aic_pkg::CODE_W-1:0] code;
      logic [aic_pkg::TIME_W-1:0] elapsed;
      logic                       blinking;
      logic                       shown;
      r = '0;
      if (cfg.block_enable) begin
         case (it.op)
            aic_pkg::OP_TICK: now_ms = now_ms + 1;
            aic_pkg::OP_SET: begin
               if (it.new_level <= aic_pkg::LEVEL_SUCCESS) begin
                  level_q     = it.new_level;
                  alert_start = now_ms;
                  alarm_on    = (it.new_level != aic_pkg::LEVEL_OFF);
                  alert_acked = 1'b0;
                  r.set_accepted = 1'b1;
               end
            end
            aic_pkg::OP_EVENT: begin
               code = (it.button_code > aic_pkg::BTN_SERVICE) ?
                      aic_pkg::BTN_UNKNOWN : it.button_code;
               elapsed = now_ms - last_press;
               if (elapsed >= cfg.debounce_time) begin
                  last_press = now_ms;
                  if (code == aic_pkg::BTN_ACK) begin
                     alert_acked = 1'b1;
                  end else if (code == aic_pkg::BTN_CLEAR) begin
                     level_q     = aic_pkg::LEVEL_OFF;
                     alarm_on    = 1'b0;
                     alert_acked = 1'b0;
                  end
                  r.event_accepted = 1'b1;
                  r.event_out      = code;
               end
            end
            default: ;
         endcase

         elapsed = now_ms - alert_start;
         if (alarm_on && !alert_acked && elapsed > cfg.alert_duration) begin
            alarm_on = 1'b0;
            level_q  = aic_pkg::LEVEL_OFF;
         end
         blinking = alarm_on && !alert_acked;
         elapsed = now_ms - last_toggle;
         if (blinking && elapsed >= cfg.blink_interval) begin
            blink_on    = ~blink_on;
            last_toggle = now_ms;
         end
         shown = blinking ? blink_on : 1'b1;
         if (shown) begin
            case (level_q)
               aic_pkg::LEVEL_CRIT: begin
                  r.led_crit  = 1'b1;
                  r.buzzer_on = cfg.buzzer_enable;
               end
               aic_pkg::LEVEL_WARN:    r.led_warn   = 1'b1;
               aic_pkg::LEVEL_INFO:    r.led_inform = 1'b1;
               aic_pkg::LEVEL_SUCCESS: r.led_ok     = 1'b1;
               default: ;
            endcase
         end
      end
      r.alert_is_active = alarm_on;
      r.alert_is_acked  = alert_acked;
      r.level_now       = level_q;
      return r;
   endfunction

   // Response side: random stalls, plus a long hold-off when a test asks for one.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (idle_on && stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 14) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_status.size() == 0) begin
            report_error("response word with no request waiting for it");
         end else begin
            status_due = expected_status.pop_front();
            want_word  = pack_status(status_due);
            if (rsp_tdata !== want_word)
               report_error($sformatf("word %0d: response is %04h, expected %04h",
                                      words_checked, rsp_tdata, want_word));
            words_checked++;
         end
      end
   end

   task automatic send_item(input logic [aic_pkg::OP_W-1:0] op,
                            input logic [aic_pkg::LEVEL_W-1:0] lvl,
                            input logic [aic_pkg::CODE_W-1:0] code);
      aic_pkg::item_type it;
      int                gap;
      it.op          = op;
      it.new_level   = lvl;
      it.button_code = code;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 14);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, code, lvl};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_status.push_back(advance_alert(it));
      items_sent++;
   endtask

   task automatic send_random_item();
      logic [31:0]                rnd;
      logic [aic_pkg::CODE_W-1:0] code;
      int                         pick;
      int                         v;
      rnd  = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         send_item(aic_pkg::OP_TICK, rnd[2:0], rnd[5:3]);
      end else if (pick < 75) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: code = aic_pkg::BTN_ACK;
            4, 5:       code = aic_pkg::BTN_CLEAR;
            default:    code = rnd[5:3];
         endcase
         send_item(aic_pkg::OP_EVENT, rnd[2:0], code);
      end else if (pick < 90) begin
         v = $urandom_range(aic_pkg::LEVEL_OFF, aic_pkg::LEVEL_SUCCESS);
         send_item(aic_pkg::OP_SET, v[aic_pkg::LEVEL_W-1:0], rnd[5:3]);
      end else if (pick < 95) begin
         send_item(OP_UNUSED, rnd[2:0], rnd[5:3]);
      end else begin
         v = $urandom_range(aic_pkg::LEVEL_SUCCESS + 1, LEVEL_TOP);
         send_item(aic_pkg::OP_SET, v[aic_pkg::LEVEL_W-1:0], rnd[5:3]);
      end
   endtask

   // Each alert episode opens with a real level and then runs a mix of ticks,
   // button presses, level changes and malformed words.
   task automatic run_traffic(input int count);
      int left;
      int burst;
      int v;
      left = count;
      while (left > 0) begin
         v = $urandom_range(aic_pkg::LEVEL_CRIT, aic_pkg::LEVEL_SUCCESS);
         send_item(aic_pkg::OP_SET, v[aic_pkg::LEVEL_W-1:0], aic_pkg::BTN_UNKNOWN);
         burst = $urandom_range(4, 40);
         if (burst > left - 1)
            burst = left - 1;
         repeat (burst) send_random_item();
         left -= burst + 1;
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [aic_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [aic_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         aic_pkg::REG_BLOCK_ENABLE:   cfg.block_enable   = value[0];
         aic_pkg::REG_BUZZER_ENABLE:  cfg.buzzer_enable  = value[0];
         aic_pkg::REG_ALERT_DURATION: cfg.alert_duration = value[aic_pkg::DURATION_W-1:0];
         aic_pkg::REG_BLINK_INTERVAL: cfg.blink_interval = value[aic_pkg::INTERVAL_W-1:0];
         aic_pkg::REG_DEBOUNCE_TIME:  cfg.debounce_time  = value[aic_pkg::INTERVAL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic en, input logic buz, input int dur,
                             input int blink, input int deb);
      wait_idle();
      write_reg(aic_pkg::REG_BLOCK_ENABLE,   {{(aic_pkg::CSR_DATA_W-1){1'b0}}, en});
      write_reg(aic_pkg::REG_BUZZER_ENABLE,  {{(aic_pkg::CSR_DATA_W-1){1'b0}}, buz});
      write_reg(aic_pkg::REG_ALERT_DURATION, dur[aic_pkg::CSR_DATA_W-1:0]);
      write_reg(aic_pkg::REG_BLINK_INTERVAL, blink[aic_pkg::CSR_DATA_W-1:0]);
      write_reg(aic_pkg::REG_DEBOUNCE_TIME,  deb[aic_pkg::CSR_DATA_W-1:0]);
      @(negedge clock);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Reset values: the debounce window is still open at time zero.
   task automatic test_startup_defaults();
      send_item(aic_pkg::OP_EVENT, aic_pkg::LEVEL_OFF, aic_pkg::BTN_ACK);
      send_item(aic_pkg::OP_SET, aic_pkg::LEVEL_CRIT, aic_pkg::BTN_UNKNOWN);
      send_item(aic_pkg::OP_SET, LEVEL_BAD, aic_pkg::BTN_UNKNOWN);
   endtask

   task automatic test_directed_cases();
      set_config(1'b1, 1'b1, 2, 1, 0);
      send_item(aic_pkg::OP_SET, aic_pkg::LEVEL_CRIT, aic_pkg::BTN_UNKNOWN);
      repeat (2) send_item(aic_pkg::OP_TICK, aic_pkg::LEVEL_OFF, aic_pkg::BTN_UNKNOWN);
      send_item(aic_pkg::OP_EVENT, aic_pkg::LEVEL_OFF, aic_pkg::BTN_ACK);
      // Every remaining level, the out-of-range ones included.
      for (int v = aic_pkg::LEVEL_WARN; v <= LEVEL_TOP; v++)
         send_item(aic_pkg::OP_SET, v[aic_pkg::LEVEL_W-1:0], aic_pkg::BTN_UNKNOWN);
      send_item(OP_UNUSED, LEVEL_ALL, CODE_ALL);
      send_item(aic_pkg::OP_EVENT, aic_pkg::LEVEL_OFF, aic_pkg::BTN_CLEAR);
      // An unacknowledged warning runs out its duration.
      send_item(aic_pkg::OP_SET, aic_pkg::LEVEL_WARN, BTN_TRAIN);
      repeat (3) send_item(aic_pkg::OP_TICK, aic_pkg::LEVEL_OFF, aic_pkg::BTN_UNKNOWN);
      for (int c = 0; c <= CODE_TOP; c++)
         send_item(aic_pkg::OP_EVENT, aic_pkg::LEVEL_OFF, c[aic_pkg::CODE_W-1:0]);
   endtask

   task automatic test_disabled_block();
      set_config(1'b0, 1'b1, 10, 2, 1);
      run_traffic(60);
   endtask

   task automatic test_config_extremes();
      set_config(1'b1, 1'b0, 0, 0, 0);
      run_traffic(150);
      set_config(1'b1, 1'b1, (1 << aic_pkg::DURATION_W) - 1,
                 (1 << aic_pkg::INTERVAL_W) - 1, (1 << aic_pkg::INTERVAL_W) - 1);
      run_traffic(150);
   endtask

   task automatic test_random_settings();
      int buz;
      int dur;
      int blink;
      int deb;
      repeat (14) begin
         buz   = $urandom_range(0, 1);
         dur   = $urandom_range(0, 60);
         blink = $urandom_range(0, 8);
         deb   = $urandom_range(0, 6);
         set_config(1'b1, buz[0], dur, blink, deb);
         run_traffic(95);
      end
   endtask

   // The response side holds off while requests keep coming, so the block
   // fills up and has to stall its input.
   task automatic test_output_backpressure();
      idle_on   = 1'b0;
      hold_left = 80;
      run_traffic(50);
      idle_on   = 1'b1;
   endtask

   task automatic test_back_to_back();
      idle_on = 1'b0;
      run_traffic(200);
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;

      cfg.block_enable   = 1'b1;
      cfg.buzzer_enable  = 1'b1;
      cfg.alert_duration = aic_pkg::RST_ALERT_DURATION;
      cfg.blink_interval = aic_pkg::RST_BLINK_INTERVAL;
      cfg.debounce_time  = aic_pkg::RST_DEBOUNCE_TIME;
      now_ms      = '0;
      level_q     = aic_pkg::LEVEL_OFF;
      alarm_on    = 1'b0;
      alert_acked = 1'b0;
      alert_start = '0;
      blink_on    = 1'b0;
      last_toggle = '0;
      last_press  = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_startup_defaults();
      test_directed_cases();
      test_disabled_block();
      test_config_extremes();
      test_random_settings();
      test_output_backpressure();
      test_back_to_back();

      wait_idle();
      if (expected_status.size() != 0)
         report_error("requests left without a response");

      $display("Sent %0d request words under %0d register settings, checked %0d responses.",
               items_sent, settings_used, words_checked);
      $display("Covered every op and level, bad codes, debounce, blink, timeout, "
               , "disabled block and output stalls.");
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #4000000;
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
